@@ hdl/tts_pkg.sv @@
// Package for the TLV tag search block: status codes, register indexes and widths.
// Depends on nothing; imported by tlv_tag_search and tlv_tag_search_tb.
`default_nettype none
package tts_pkg;

  localparam int unsigned TAG_W  = 16;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned HDR_W  = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [HDR_W-1:0] HDR_LAST = 3'd5;

  localparam logic [STAT_W-1:0] ST_FOUND   = 2'd0;
  localparam logic [STAT_W-1:0] ST_TRUNC   = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERRUN = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_TAG    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 1'd1;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  value_offset;
    logic [LEN_W-1:0]  value_length;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/tlv_tag_search.sv @@
// TLV tag search: walks 6-byte tag/length headers and values, one per cycle unless stalled.
// Depends on tts_pkg for status codes, register indexes and the result type.
//
//   channel | dir | handshake          | payload
//   in      | in  | in_tvalid/tready   | tdata: data_byte; tuser: first_of_buffer
//   out     | out | out_tvalid/tready  | tdata: status, value_offset, value_length
//   cfg     | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// One item is taken per cycle unless stalled; a result waits in the skid if out_r is stalled.
// The search state updates in the accepting cycle from 33-bit adds and compares.
// An output register plus a skid register hold results; input stalls only when both are full.
// Reset is synchronous, active low; the block then idles until a first-marked item.
`default_nettype none
module tlv_tag_search (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [tts_pkg::BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  wire logic                            in_tuser,   // [0] first_of_buffer
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [tts_pkg::OUT_DATA_W-1:0]       out_tdata,  // [1:0] status, [33:2] value_offset,
                                                           // [65:34] value_length, [71:66] zero
  input  wire logic                            cfg_wr_en,
  input  wire logic [tts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tts_pkg::*;

  logic [TAG_W-1:0] search_tag_r;
  logic [LEN_W-1:0] buffer_length_r;

  logic [LEN_W-1:0] byte_position_r, byte_position_nxt;
  logic [HDR_W-1:0] header_byte_index_r, header_byte_index_nxt;
  logic [TAG_W-1:0] tag_shift_r, tag_shift_nxt;
  logic [LEN_W-1:0] length_shift_r, length_shift_nxt;
  logic [LEN_W-1:0] skip_remaining_r, skip_remaining_nxt;
  logic             in_value_phase_r, in_value_phase_nxt;
  logic             search_done_r, search_done_nxt;

  result_t out_r, skid_r, res_nxt;
  logic    out_valid_r, skid_valid_r;
  logic    res_valid;
  logic    accept, pop;

  logic [LEN_W:0] pos_ext, next_ext, blen_ext;

  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign pop        = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - STAT_W - 2*LEN_W){1'b0}},
                       out_r.value_length, out_r.value_offset, out_r.status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_tag_r    <= '0;
      buffer_length_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SEARCH_TAG:    search_tag_r    <= cfg_wdata[TAG_W-1:0];
        REG_BUFFER_LENGTH: buffer_length_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic             first;
    logic [LEN_W-1:0] pos_base;
    logic [LEN_W-1:0] skip_base;
    logic [HDR_W-1:0] hdr_base;
    logic [TAG_W-1:0] tag_base;
    logic [LEN_W-1:0] len_base;
    logic             phase_base;
    logic             done_base;

    first      = in_tuser;
    pos_base   = first ? '0 : byte_position_r;
    hdr_base   = first ? '0 : header_byte_index_r;
    tag_base   = first ? '0 : tag_shift_r;
    len_base   = first ? '0 : length_shift_r;
    skip_base  = first ? '0 : skip_remaining_r;
    phase_base = first ? 1'b0 : in_value_phase_r;
    done_base  = first ? 1'b0 : search_done_r;

    byte_position_nxt     = pos_base;
    header_byte_index_nxt = hdr_base;
    tag_shift_nxt         = tag_base;
    length_shift_nxt      = len_base;
    skip_remaining_nxt    = skip_base;
    in_value_phase_nxt    = phase_base;
    search_done_nxt       = done_base;

    pos_ext  = {1'b0, pos_base};
    next_ext = pos_ext + {{LEN_W{1'b0}}, 1'b1};
    blen_ext = {1'b0, buffer_length_r};

    res_valid            = 1'b0;
    res_nxt.status       = ST_FOUND;
    res_nxt.value_offset = '0;
    res_nxt.value_length = len_base;

    if (!done_base) begin
      byte_position_nxt = next_ext[LEN_W-1:0];
      if (phase_base) begin
        skip_remaining_nxt = skip_base - LEN_W'(1);
        if (skip_remaining_nxt == '0) begin
          in_value_phase_nxt = 1'b0;
          if (next_ext >= blen_ext) begin
            res_valid      = 1'b1;
            res_nxt.status = ST_NOMATCH;
          end
        end
      end else if (hdr_base == '0 && pos_ext >= blen_ext) begin
        res_valid      = 1'b1;
        res_nxt.status = ST_NOMATCH;
      end else if (hdr_base == '0 && (pos_ext + (LEN_W+1)'(6)) > blen_ext) begin
        res_valid      = 1'b1;
        res_nxt.status = ST_TRUNC;
      end else begin
        if (hdr_base < HDR_W'(2)) begin
          tag_shift_nxt = {tag_base[TAG_W-BYTE_W-1:0], in_tdata};
        end else begin
          length_shift_nxt = {len_base[LEN_W-BYTE_W-1:0], in_tdata};
        end
        if (hdr_base != HDR_LAST) begin
          header_byte_index_nxt = hdr_base + HDR_W'(1);
        end else begin
          header_byte_index_nxt = '0;
          res_nxt.value_length  = length_shift_nxt;
          priority if ((next_ext + {1'b0, length_shift_nxt}) > blen_ext) begin
            res_valid      = 1'b1;
            res_nxt.status = ST_OVERRUN;
          end else if (tag_shift_nxt == search_tag_r) begin
            res_valid            = 1'b1;
            res_nxt.status       = ST_FOUND;
            res_nxt.value_offset = next_ext[LEN_W-1:0];
          end else if (length_shift_nxt == '0) begin
            if (next_ext >= blen_ext) begin
              res_valid      = 1'b1;
              res_nxt.status = ST_NOMATCH;
            end
          end else begin
            skip_remaining_nxt = length_shift_nxt;
            in_value_phase_nxt = 1'b1;
          end
        end
      end
      if (res_valid) begin
        search_done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r     <= '0;
      header_byte_index_r <= '0;
      tag_shift_r         <= '0;
      length_shift_r      <= '0;
      skip_remaining_r    <= '0;
      in_value_phase_r    <= 1'b0;
      search_done_r       <= 1'b1;
    end else if (accept) begin
      byte_position_r     <= byte_position_nxt;
      header_byte_index_r <= header_byte_index_nxt;
      tag_shift_r         <= tag_shift_nxt;
      length_shift_r      <= length_shift_nxt;
      skip_remaining_r    <= skip_remaining_nxt;
      in_value_phase_r    <= in_value_phase_nxt;
      search_done_r       <= search_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (accept && res_valid) begin
      if (!out_valid_r || pop) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item while output register is empty");

  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    header_byte_index_r <= HDR_LAST)
    else $error("header byte index out of range");

  a_value_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_value_phase_r |-> (skip_remaining_r != '0 && header_byte_index_r == '0))
    else $error("value phase with no bytes to skip or mid-header");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status == ST_FOUND || out_r.value_offset == '0))
    else $error("nonzero value offset on a failure result");

  a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_valid) |=> search_done_r)
    else $error("search still active after a result");

endmodule
`default_nettype wire

@@ tb/tlv_tag_search_tb.sv @@
// Testbench for tlv_tag_search: streams tag-length-value buffers through the block and
// checks every result against a scoreboard that tracks the record walk byte by byte.
// Depends on tts_pkg and tlv_tag_search.
`timescale 1ns / 100ps
module tlv_tag_search_tb;
  import tts_pkg::*;

  class tlv_search_scoreboard;
    logic [TAG_W-1:0] tag_reg;
    logic [LEN_W-1:0] blen_reg;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] len_acc;
    logic [LEN_W-1:0] skip_left;
    logic [TAG_W-1:0] tag_acc;
    logic [HDR_W-1:0] hdr_idx;
    bit               in_value;
    bit               done;
    result_t          pending[$];
    int               n_items;
    int               n_active;
    int               n_results;
    int               n_errors;
    int               by_status[4];

    function new();
      tag_reg   = '0;
      blen_reg  = '0;
      pos       = '0;
      len_acc   = '0;
      skip_left = '0;
      tag_acc   = '0;
      hdr_idx   = '0;
      in_value  = 1'b0;
      done      = 1'b1;
      n_items   = 0;
      n_active  = 0;
      n_results = 0;
      n_errors  = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      if (idx == REG_SEARCH_TAG)
        tag_reg = v[TAG_W-1:0];
      else if (idx == REG_BUFFER_LENGTH)
        blen_reg = v[LEN_W-1:0];
    endfunction

    function void post(logic [STAT_W-1:0] st, logic [LEN_W-1:0] off);
      result_t r;
      r.status       = st;
      r.value_offset = off;
      r.value_length = len_acc;
      pending.push_back(r);
      done = 1'b1;
    endfunction

    function void note_item(logic [BYTE_W-1:0] b, logic first);
      logic [LEN_W+1:0] cur;
      logic [LEN_W+1:0] nxt;
      logic [LEN_W+1:0] blen;
      n_items++;
      if (first) begin
        pos       = '0;
        hdr_idx   = '0;
        tag_acc   = '0;
        len_acc   = '0;
        skip_left = '0;
        in_value  = 1'b0;
        done      = 1'b0;
      end
      if (done)
        return;
      n_active++;
      cur  = {2'b00, pos};
      nxt  = cur + 1;
      blen = {2'b00, blen_reg};
      pos  = nxt[LEN_W-1:0];
      if (in_value) begin
        skip_left = skip_left - 1;
        if (skip_left == '0) begin
          in_value = 1'b0;
          if (nxt >= blen)
            post(ST_NOMATCH, '0);
        end
        return;
      end
      if (hdr_idx == '0) begin
        if (cur >= blen) begin
          post(ST_NOMATCH, '0);
          return;
        end
        if (cur + 6 > blen) begin
          post(ST_TRUNC, '0);
          return;
        end
      end
      if (hdr_idx < 2)
        tag_acc = {tag_acc[7:0], b};
      else
        len_acc = {len_acc[LEN_W-9:0], b};
      if (hdr_idx != HDR_LAST) begin
        hdr_idx = hdr_idx + HDR_W'(1);
        return;
      end
      hdr_idx = '0;
      if (nxt + {2'b00, len_acc} > blen)
        post(ST_OVERRUN, '0);
      else if (tag_acc == tag_reg)
        post(ST_FOUND, nxt[LEN_W-1:0]);
      else if (len_acc == '0) begin
        if (nxt >= blen)
          post(ST_NOMATCH, '0);
      end else begin
        skip_left = len_acc;
        in_value  = 1'b1;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      result_t got;
      result_t want;
      got.status       = d[STAT_W-1:0];
      got.value_offset = d[STAT_W+LEN_W-1:STAT_W];
      got.value_length = d[STAT_W+2*LEN_W-1:STAT_W+LEN_W];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: status %0d offset %0h length %0h",
                 $time, got.status, got.value_offset, got.value_length);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      n_results++;
      by_status[want.status]++;
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        n_errors++;
      end
      if (got.value_offset !== want.value_offset) begin
        $display("%0t: value_offset mismatch: expected %0h, actual %0h",
                 $time, want.value_offset, got.value_offset);
        n_errors++;
      end
      if (got.value_length !== want.value_length) begin
        $display("%0t: value_length mismatch: expected %0h, actual %0h",
                 $time, want.value_length, got.value_length);
        n_errors++;
      end
    endfunction
  endclass

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [BYTE_W-1:0]       in_tdata   = '0;
  logic                    in_tuser   = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata  = '0;

  tlv_search_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  tlv_tag_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      hold_left  <= 300;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata);
      if (in_tvalid && in_tready)
        sb.note_item(in_tdata, in_tuser);
      if (cfg_wr_en)
        sb.set_reg(cfg_index, cfg_wdata);
    end
  end

  task automatic put_byte(input logic [BYTE_W-1:0] d, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
  endtask

  task automatic write_config(input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] blen);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SEARCH_TAG;
    cfg_wdata <= {{(CFG_DATA_W-TAG_W){1'b0}}, tag};
    @(posedge clk);
    cfg_index <= REG_BUFFER_LENGTH;
    cfg_wdata <= blen;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_buffer();
    logic [BYTE_W-1:0] stream[$];
    logic [TAG_W-1:0]  tag;
    logic [TAG_W-1:0]  rec_tag;
    logic [LEN_W-1:0]  blen;
    logic [LEN_W-1:0]  len;
    longint            pos;
    int                kind;
    int                sel;
    int                keep;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(20, 1))
        put_byte(BYTE_W'($urandom), $urandom_range(7) == 0);
      return;
    end
    settle();
    sel = $urandom_range(99);
    tag = (sel < 10) ? '0 : (sel < 20) ? '1 : TAG_W'($urandom);
    if (kind < 15)
      blen = '1;
    else if (kind < 20)
      blen = $urandom;
    else if (kind < 28)
      blen = $urandom_range(5);
    else
      blen = $urandom_range(64, 6);
    write_config(tag, blen);
    pos = 0;
    while (pos < 80) begin
      sel = $urandom_range(9);
      rec_tag = (sel < 3) ? tag : (sel < 5) ? tag ^ (16'd1 << $urandom_range(15)) :
                TAG_W'($urandom);
      sel = $urandom_range(99);
      if (sel < 55)
        len = $urandom_range(8);
      else if (sel < 75)
        len = (pos + 6 <= blen) ? blen - 32'(pos) - 32'd6 : '0;
      else if (sel < 88)
        len = blen - 32'(pos) - 32'd6 + $urandom_range(3, 1);
      else
        len = $urandom;
      stream.push_back(rec_tag[15:8]);
      stream.push_back(rec_tag[7:0]);
      stream.push_back(len[31:24]);
      stream.push_back(len[23:16]);
      stream.push_back(len[15:8]);
      stream.push_back(len[7:0]);
      if (len > 16)
        break;
      repeat (len) stream.push_back(BYTE_W'($urandom));
      pos = pos + 6 + len;
      if (pos >= blen)
        break;
    end
    repeat ($urandom_range(3)) stream.push_back(BYTE_W'($urandom));
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(stream.size(), 1);
      while (stream.size() > keep)
        void'(stream.pop_back());
    end
    foreach (stream[i])
      put_byte(stream[i], (i == 0) || ($urandom_range(49) == 0));
  endtask

  initial begin
    int target;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_byte(8'hAA, 1'b0);
    put_byte(8'h55, 1'b0);
    put_byte(8'h00, 1'b1);
    settle();
    write_config(16'hFFFF, 32'd5);
    put_byte(8'hFF, 1'b1);
    settle();
    write_config(16'hFFFF, 32'hFFFF_FFFF);
    put_byte(8'hFF, 1'b1);
    repeat (5) put_byte(8'hFF, 1'b0);
    settle();
    write_config(16'h0000, 32'hFFFF_FFFF);
    put_byte(8'h00, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hF0, 1'b0);
    settle();
    write_config(16'h0001, 32'd6);
    put_byte(8'h00, 1'b1);
    put_byte(8'h02, 1'b0);
    repeat (4) put_byte(8'h00, 1'b0);
    settle();
    write_config(16'h00A5, 32'd12);
    put_byte(8'h00, 1'b1);
    put_byte(8'hA5, 1'b0);
    put_byte(8'h12, 1'b1);
    put_byte(8'h34, 1'b0);
    settle();
    write_config(16'h1234, 32'd12);
    repeat (3) put_byte(8'h00, 1'b0);
    put_byte(8'h02, 1'b0);
    settle();

    // hold the result side off while short buffers keep coming
    write_config(16'h0000, 32'd3);
    hold_seq <= hold_seq + 1;
    repeat (24) put_byte(BYTE_W'($urandom), 1'b1);
    settle();

    for (int m = 0; m < 4; m++) begin
      send_idle_pct = (m == 1) ? 88 : (m == 3) ? 28 : 0;
      stall_pct    <= (m == 2) ? 88 : (m == 3) ? 28 : 0;
      target = sb.n_items + 320;
      while (sb.n_items < target)
        run_buffer();
    end
    settle();

    $display("sent %0d items, %0d inside an active search, checked %0d results",
             sb.n_items, sb.n_active, sb.n_results);
    $display("outcomes: found %0d, truncated %0d, overrun %0d, no match %0d",
             sb.by_status[ST_FOUND], sb.by_status[ST_TRUNC],
             sb.by_status[ST_OVERRUN], sb.by_status[ST_NOMATCH]);
    if (sb.n_errors == 0)
      $display("tlv_tag_search_tb passed");
    else
      $display("tlv_tag_search_tb failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("tlv_tag_search_tb failed");
    $finish;
  end
endmodule
